@@ design/hash_table_linear_probe_assert.svh @@
// Assertion macros shared by the hash table RTL.
`ifndef HASH_TABLE_LINEAR_PROBE_ASSERT_SVH
`define HASH_TABLE_LINEAR_PROBE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define HLTP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define HLTP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

@@ design/hltp_pkg.sv @@
// Package: constants, codes, state and handshake types of the hash table.
package hltp_pkg;

	localparam int unsigned CAPACITY_DEF   = 1024;
	localparam int unsigned VALUE_BITS_DEF = 64;
	localparam int unsigned HOME_W         = 17;
	localparam logic [63:0] HASH_OFFSET    = 64'd14695981039346656037;
	localparam int unsigned HASH_SHIFT     = 15;
	localparam int unsigned COUNT_W        = 11;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_SPARE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_ABSENT = 2'd1,
		STS_FULL   = 2'd2,
		STS_ZERO   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_HASH,
		SQ_RD,
		SQ_CHK,
		SQ_DEL_STEP,
		SQ_DEL_RD,
		SQ_DEL_CHK,
		SQ_DEL_HASH,
		SQ_DEL_END,
		SQ_DONE
	} state_t;

	// Request into the hash unit
	typedef struct packed {
		logic        start;
		logic [63:0] key;
	} hash_req_t;

	// Answer from the hash unit
	typedef struct packed {
		logic              done;
		logic [HOME_W-1:0] home;
	} hash_rsp_t;

endpackage

@@ design/hltp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hltp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ design/hltp_hash.sv @@
// Home slot unit: 64-bit hash over one shared 32x32 multiplier, then reduction.
module hltp_hash #(
	parameter int unsigned CAPACITY = hltp_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hltp_pkg::hash_req_t req,
	output hltp_pkg::hash_rsp_t rsp
);
	import hltp_pkg::*;

	localparam int unsigned IDXW = $clog2(CAPACITY);
	localparam bit          POW2 = (CAPACITY == (1 << IDXW));
	// Reciprocal for the digit reduction: floor(2^(31+IDXW) / CAPACITY)
	localparam logic [63:0] RECIP_W = (64'd1 << (31 + IDXW)) / 64'(CAPACITY);
	localparam logic [31:0] RECIP   = RECIP_W[31:0];
	localparam logic [31:0] CAP_C   = 32'(CAPACITY);

	logic              busy_q, mod_q, done_q, sub_q;
	logic [1:0]        phase_q, dig_q;
	logic [63:0]       key_q, acc_q, h_q;
	logic [31:0]       quo_q;
	logic [15:0]       rem_q;
	logic [IDXW-1:0]   home_q;
	logic [31:0]       mul_a, mul_b;
	logic [63:0]       prod, hash_w;
	logic [31:0]       num, quo, diff, fixed;

	// Shared multiplier operand select: hash partial products, then reduction
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (mod_q) begin
			if (sub_q) begin
				mul_a = quo_q;
				mul_b = CAP_C;
			end else begin
				mul_a = num;
				mul_b = RECIP;
			end
		end else begin
			case (phase_q)
				2'd0: begin mul_a = HASH_OFFSET[31:0];  mul_b = key_q[31:0];  end
				2'd1: begin mul_a = HASH_OFFSET[31:0];  mul_b = key_q[63:32]; end
				2'd2: begin mul_a = HASH_OFFSET[63:32]; mul_b = key_q[31:0];  end
				default: ;
			endcase
		end
	end

	assign prod   = 64'(mul_a) * 64'(mul_b);
	assign hash_w = acc_q ^ (key_q >> HASH_SHIFT);
	// One 16-bit digit of the modulo: estimate quotient, subtract, correct once
	assign num    = {rem_q, h_q[{dig_q, 4'd0} +: 16]};
	assign quo    = 32'(prod >> (31 + IDXW));
	assign diff   = num - prod[31:0];
	assign fixed  = (diff >= CAP_C) ? diff - CAP_C : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			mod_q   <= 1'b0;
			done_q  <= 1'b0;
			sub_q   <= 1'b0;
			phase_q <= '0;
			dig_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				mod_q   <= 1'b0;
				phase_q <= '0;
			end else if (busy_q && !mod_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					if (POW2) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						mod_q <= 1'b1;
						sub_q <= 1'b0;
						dig_q <= 2'd3;
					end
				end
			end else if (busy_q && mod_q) begin
				sub_q <= ~sub_q;
				if (sub_q) begin
					dig_q <= dig_q - 2'd1;
					if (dig_q == 2'd0) begin
						busy_q <= 1'b0;
						mod_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Datapath: accumulate low 64 bits of the product, then reduce
	always_ff @(posedge clk) begin
		if (req.start) begin
			key_q <= req.key;
		end else if (busy_q && !mod_q) begin
			case (phase_q)
				2'd0: acc_q <= prod;
				2'd1, 2'd2: acc_q <= acc_q + {prod[31:0], 32'd0};
				default: begin
					h_q    <= hash_w;
					rem_q  <= '0;
					home_q <= hash_w[IDXW-1:0];
				end
			endcase
		end else if (busy_q && mod_q) begin
			if (!sub_q) begin
				quo_q <= quo;
			end else begin
				rem_q <= fixed[15:0];
				if (dig_q == 2'd0) home_q <= IDXW'(fixed);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.home = HOME_W'(home_q);
endmodule

@@ design/hash_table_linear_probe.sv @@
// Top level: open-addressing key/value table with linear probing.
// Usage:
//  Requests enter on s_tvalid/s_tready. s_tuser is the request type
//  (lookup, insert or update, remove); s_tdata is key then value.
//  Each request returns one transaction on m_tvalid/m_tready: m_tuser is
//  the status, m_tdata is found value then entry count.
//  A zero key skips hashing and probing and goes straight to the result.
//  Otherwise the 64-bit hash runs on the shared 32x32 multiplier (followed
//  by a reduction, one 16-bit digit at a time, when CAPACITY is not a power
//  of two), then each probe reads one slot on the single RAM read port.
//  The next request can be taken once the result is in the output register.
//  A remove also scans, rehashes and may shift back each occupied slot
//  behind the removed key. One request is in flight at a time.
//  Reset: the RAM occupancy bits are cleared by a pass of CAPACITY cycles
//  after reset; s_tready stays low until it ends.
//  Stall: the result sits in an output register; the next request is
//  accepted meanwhile, and its own result waits until that one is taken.
module hash_table_linear_probe #(
	parameter int unsigned CAPACITY   = hltp_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_BITS = hltp_pkg::VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // [63:0] key, [127:64] value
	input  logic [1:0]   s_tuser,   // [1:0] req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,   // [63:0] found_value, [74:64] entry_count, zero pad
	output logic [1:0]   m_tuser    // [1:0] status
);
	import hltp_pkg::*;

	localparam int unsigned IDXW = $clog2(CAPACITY);
	localparam int unsigned CNTW = $clog2(CAPACITY + 1);
	localparam int unsigned ENTW = 1 + 64 + VALUE_BITS;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);

	state_t                state_q, state_d;
	req_t                  req_q;
	logic [63:0]           key_q, mkey_q;
	logic [VALUE_BITS-1:0] val_q, mval_q, found_q;
	logic [IDXW-1:0]       idx_q, n_q, hole_q, clr_q;
	logic [CNTW-1:0]       cnt_q;
	status_t               sts_q;
	logic                  m_tvalid_q;
	logic [1:0]            m_tuser_q;
	logic [79:0]           m_tdata_q;

	logic                  we;
	logic [IDXW-1:0]       waddr;
	logic [ENTW-1:0]       wdata, rdata;
	logic                  r_used;
	logic [63:0]           r_key;
	logic [VALUE_BITS-1:0] r_val;
	logic [IDXW-1:0]       idx_next, home;
	logic                  move;
	hash_req_t             hreq;
	hash_rsp_t             hrsp;
	logic                  s_acc;

	hltp_ram #(.WIDTH(ENTW), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	hltp_hash #(.CAPACITY(CAPACITY)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	assign r_used   = rdata[ENTW-1];
	assign r_key    = rdata[ENTW-2 -: 64];
	assign r_val    = rdata[VALUE_BITS-1:0];
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign home     = hrsp.home[IDXW-1:0];
	assign s_tready = (state_q == SQ_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// Backward-shift test: entry at idx_q may fill the hole
	always_comb begin
		if (idx_q > hole_q) move = (home <= hole_q) || (home > idx_q);
		else                move = (home <= hole_q) && (home > idx_q);
	end

	// Next state, RAM write port and hash requests
	always_comb begin
		state_d    = state_q;
		we         = 1'b0;
		waddr      = idx_q;
		wdata      = {1'b1, key_q, val_q};
		hreq.start = 1'b0;
		hreq.key   = s_tdata[63:0];
		case (state_q)
			SQ_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == LAST_IDX) state_d = SQ_IDLE;
			end
			SQ_IDLE: begin
				if (s_acc) begin
					if (s_tdata[63:0] == 64'd0) begin
						state_d = SQ_DONE;
					end else begin
						hreq.start = 1'b1;
						state_d    = SQ_HASH;
					end
				end
			end
			SQ_HASH: begin
				if (hrsp.done) state_d = SQ_RD;
			end
			SQ_RD: state_d = SQ_CHK;
			SQ_CHK: begin
				if (!r_used) begin
					we      = (req_q == REQ_INSERT);
					state_d = SQ_DONE;
				end else if (r_key == key_q) begin
					we      = (req_q == REQ_INSERT);
					state_d = (req_q == REQ_REMOVE) ? SQ_DEL_STEP : SQ_DONE;
				end else if (n_q == LAST_IDX) begin
					state_d = SQ_DONE;
				end else begin
					state_d = SQ_RD;
				end
			end
			SQ_DEL_STEP: begin
				state_d = (idx_next == hole_q) ? SQ_DEL_END : SQ_DEL_RD;
			end
			SQ_DEL_RD: state_d = SQ_DEL_CHK;
			SQ_DEL_CHK: begin
				if (!r_used) begin
					state_d = SQ_DEL_END;
				end else begin
					hreq.start = 1'b1;
					hreq.key   = r_key;
					state_d    = SQ_DEL_HASH;
				end
			end
			SQ_DEL_HASH: begin
				if (hrsp.done) begin
					we      = move;
					waddr   = hole_q;
					wdata   = {1'b1, mkey_q, mval_q};
					state_d = SQ_DEL_STEP;
				end
			end
			SQ_DEL_END: begin
				we      = 1'b1;
				waddr   = hole_q;
				wdata   = '0;
				state_d = SQ_DONE;
			end
			SQ_DONE: begin
				if (!m_tvalid_q || m_tready) state_d = SQ_IDLE;
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= SQ_CLEAR;
		else         state_q <= state_d;
	end

	// Control registers: clear sweep, count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == SQ_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == SQ_CHK && !r_used && req_q == REQ_INSERT) cnt_q <= cnt_q + 1'b1;
			if (state_q == SQ_DEL_END && cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			if (state_q == SQ_DONE && (!m_tvalid_q || m_tready)) m_tvalid_q <= 1'b1;
		end
	end

	// Request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (s_acc) begin
					req_q   <= req_t'(s_tuser);
					key_q   <= s_tdata[63:0];
					val_q   <= s_tdata[64 +: VALUE_BITS];
					found_q <= '0;
					sts_q   <= (s_tdata[63:0] == 64'd0) ? STS_ZERO : STS_OK;
				end
			end
			SQ_HASH: begin
				idx_q <= home;
				n_q   <= '0;
			end
			SQ_CHK: begin
				if (!r_used) begin
					sts_q <= (req_q == REQ_INSERT) ? STS_OK : STS_ABSENT;
				end else if (r_key == key_q) begin
					sts_q  <= STS_OK;
					hole_q <= idx_q;
					if (req_q != REQ_INSERT && req_q != REQ_REMOVE) found_q <= r_val;
				end else if (n_q == LAST_IDX) begin
					sts_q <= (req_q == REQ_INSERT) ? STS_FULL : STS_ABSENT;
				end else begin
					n_q   <= n_q + 1'b1;
					idx_q <= idx_next;
				end
			end
			SQ_DEL_STEP: idx_q <= idx_next;
			SQ_DEL_CHK: begin
				mkey_q <= r_key;
				mval_q <= r_val;
			end
			SQ_DEL_HASH: begin
				if (hrsp.done && move) hole_q <= idx_q;
			end
			SQ_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tuser_q <= sts_q;
					m_tdata_q <= {5'd0, COUNT_W'(cnt_q), 64'(found_q)};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	`include "hash_table_linear_probe_assert.svh"

	`HLTP_ASSERT_ALWAYS(a_cnt_cap, cnt_q <= CNTW'(CAPACITY), "entry count above capacity")
	`HLTP_ASSERT_IMP(a_cnt_step, !$stable(cnt_q), cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1, "entry count moved by more than one")
	`HLTP_ASSERT_IMP(a_out_load, $rose(m_tvalid_q), $past(state_q == SQ_DONE), "result shown outside completion")
	`HLTP_ASSERT_IMP(a_no_acc_clear, state_q == SQ_CLEAR, !s_tready, "request taken during clear pass")
endmodule
